// File: rtl/core/bcm_pkg.sv
// Shared types, constants, denomination tables and microprogram for the change maker.
`default_nettype none
package bcm_pkg;

    localparam int DENOM_SLOTS  = 8;
    localparam int DK_W         = 3;
    localparam int AMT_W        = 17;
    localparam int CNT_W        = 8;
    localparam int DVAL_W       = 8;
    localparam int RECIP_W      = 25;
    localparam int RECIP_SHIFT  = 24;
    localparam int PROD_W       = AMT_W + RECIP_W;
    localparam int QD_W         = AMT_W + DVAL_W;
    localparam int TD_W         = CNT_W + DVAL_W;
    localparam int CFG_IDX_W    = 4;
    localparam int UPC_W        = 4;

    typedef logic [3:0] t_op;
    typedef logic [3:0] t_cond;
    typedef logic [UPC_W-1:0] t_upc;

    // Datapath operations.
    localparam t_op OP_NOP   = 4'd0;
    localparam t_op OP_INIT  = 4'd1;
    localparam t_op OP_MUL1  = 4'd2;
    localparam t_op OP_QEST  = 4'd3;
    localparam t_op OP_MUL2  = 4'd4;
    localparam t_op OP_CORR  = 4'd5;
    localparam t_op OP_TAKE  = 4'd6;
    localparam t_op OP_SUB   = 4'd7;
    localparam t_op OP_LEAST = 4'd8;
    localparam t_op OP_DEC   = 4'd9;
    localparam t_op OP_GIVE  = 4'd10;
    localparam t_op OP_SETOK = 4'd11;
    localparam t_op OP_FAIL  = 4'd12;
    localparam t_op OP_EMIT  = 4'd13;

    // Jump conditions.
    localparam t_cond C_NEVER  = 4'd0;
    localparam t_cond C_ALWAYS = 4'd1;
    localparam t_cond C_NSTART = 4'd2;
    localparam t_cond C_JEND   = 4'd3;
    localparam t_cond C_SUBNZ  = 4'd4;
    localparam t_cond C_REMZ   = 4'd5;
    localparam t_cond C_JZERO  = 4'd6;
    localparam t_cond C_MISS   = 4'd7;
    localparam t_cond C_OBUSY  = 4'd8;

    // Microprogram entry points.
    localparam t_upc U_IDLE = 4'd0;
    localparam t_upc U_FCHK = 4'd1;
    localparam t_upc U_FEND = 4'd8;
    localparam t_upc U_SRCH = 4'd9;
    localparam t_upc U_DONE = 4'd12;
    localparam t_upc U_FAIL = 4'd13;
    localparam t_upc U_EMIT = 4'd14;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  tgt;
    } t_uword;

    typedef struct packed {
        logic j_end;
        logic sub_nz;
        logic rem_zero;
        logic j_zero;
        logic miss;
    } t_dstat;

    typedef struct packed {
        logic   nstart;
        logic   out_busy;
        t_dstat dp;
    } t_flags;

    function automatic logic [DVAL_W-1:0] denom_val(input logic [DK_W-1:0] k);
        logic [DVAL_W-1:0] v;
        case (k)
            3'd0:    v = 8'd200;
            3'd1:    v = 8'd100;
            3'd2:    v = 8'd50;
            3'd3:    v = 8'd20;
            3'd4:    v = 8'd10;
            3'd5:    v = 8'd5;
            3'd6:    v = 8'd2;
            default: v = 8'd1;
        endcase
        return v;
    endfunction

    // floor(2^24 / d); the quotient estimate is low by at most one.
    function automatic logic [RECIP_W-1:0] denom_recip(input logic [DK_W-1:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            3'd0:    r = 25'd83886;
            3'd1:    r = 25'd167772;
            3'd2:    r = 25'd335544;
            3'd3:    r = 25'd838860;
            3'd4:    r = 25'd1677721;
            3'd5:    r = 25'd3355443;
            3'd6:    r = 25'd8388608;
            default: r = 25'd16777216;
        endcase
        return r;
    endfunction

    function automatic t_uword ucode(input t_upc a);
        t_uword w;
        case (a)
            4'd0:    w = '{op: OP_INIT,  cond: C_NSTART, tgt: U_IDLE};
            4'd1:    w = '{op: OP_NOP,   cond: C_JEND,   tgt: U_FEND};
            4'd2:    w = '{op: OP_MUL1,  cond: C_NEVER,  tgt: U_IDLE};
            4'd3:    w = '{op: OP_QEST,  cond: C_NEVER,  tgt: U_IDLE};
            4'd4:    w = '{op: OP_MUL2,  cond: C_NEVER,  tgt: U_IDLE};
            4'd5:    w = '{op: OP_CORR,  cond: C_NEVER,  tgt: U_IDLE};
            4'd6:    w = '{op: OP_TAKE,  cond: C_NEVER,  tgt: U_IDLE};
            4'd7:    w = '{op: OP_SUB,   cond: C_SUBNZ,  tgt: U_FCHK};
            4'd8:    w = '{op: OP_LEAST, cond: C_REMZ,   tgt: U_DONE};
            4'd9:    w = '{op: OP_DEC,   cond: C_JZERO,  tgt: U_FAIL};
            4'd10:   w = '{op: OP_NOP,   cond: C_MISS,   tgt: U_SRCH};
            4'd11:   w = '{op: OP_GIVE,  cond: C_ALWAYS, tgt: U_FCHK};
            4'd12:   w = '{op: OP_SETOK, cond: C_ALWAYS, tgt: U_EMIT};
            4'd13:   w = '{op: OP_FAIL,  cond: C_ALWAYS, tgt: U_EMIT};
            4'd14:   w = '{op: OP_EMIT,  cond: C_OBUSY,  tgt: U_EMIT};
            default: w = '{op: OP_NOP,   cond: C_ALWAYS, tgt: U_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/bounded_change_maker_top.sv
// Top level of the bounded change maker: stock registers, sequencer, datapath, result register.
`default_nettype none
// Breaks an amount into 200/100/50/20/10/5/2/1 pieces without exceeding the programmed
// stock, using a greedy pass with give-back search when the greedy result leaves a
// remainder. One request is worked at a time; the result waits in an output register so a
// new request is taken once the previous result has moved into that register. Each
// denomination visited by a greedy pass goes through an end check, multiply, quotient
// estimate, multiply, correction, take and subtract, and every pass ends with a step that
// records the smallest remainder. Each give-back search scans denominations from the
// smallest upward and then gives one piece back. The exit marks the result ok or failed,
// emits it once the output register is free and returns to idle; time per request grows
// with the number of give-back steps. Stock registers are written through the config
// channel, which is always ready; the user must write them only while no request is in
// flight, and the block itself does not enforce this.
module bounded_change_maker_top #(
    parameter int NUM_DENOMS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bcm_pkg::AMT_W-1:0]     i_amount,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_paid_ok,
    output logic [bcm_pkg::AMT_W-1:0]     o_shortfall,
    output logic [bcm_pkg::CNT_W-1:0]     o_give_200,
    output logic [bcm_pkg::CNT_W-1:0]     o_give_100,
    output logic [bcm_pkg::CNT_W-1:0]     o_give_50,
    output logic [bcm_pkg::CNT_W-1:0]     o_give_20,
    output logic [bcm_pkg::CNT_W-1:0]     o_give_10,
    output logic [bcm_pkg::CNT_W-1:0]     o_give_5,
    output logic [bcm_pkg::CNT_W-1:0]     o_give_2,
    output logic [bcm_pkg::CNT_W-1:0]     o_give_1,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bcm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bcm_pkg::CNT_W-1:0]     i_cfg_data
);
    import bcm_pkg::*;

    logic [CNT_W-1:0] r_stock [DENOM_SLOTS];
    logic             r_ovalid;
    logic             r_paid_ok;
    logic [AMT_W-1:0] r_shortfall;
    logic [CNT_W-1:0] r_give [DENOM_SLOTS];

    t_op              seq_op;
    t_op              dp_op;
    t_flags           flags;
    t_dstat           dp_stat;
    logic             dp_ok;
    logic [AMT_W-1:0] dp_least;
    logic [CNT_W-1:0] dp_cnt [NUM_DENOMS];
    logic [CNT_W-1:0] give_n [DENOM_SLOTS];
    logic             out_free;
    logic             emit;

    assign out_free = !r_ovalid || !i_stall;
    assign emit     = (seq_op == OP_EMIT) && out_free;

    // Initialization only happens on a beat that is really taken.
    assign dp_op = ((seq_op == OP_INIT) && !i_valid) ? OP_NOP : seq_op;

    assign flags.nstart   = !i_valid;
    assign flags.out_busy = !out_free;
    assign flags.dp       = dp_stat;

    bcm_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_op    (seq_op)
    );

    bcm_dpath #(
        .NUM_DENOMS (NUM_DENOMS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (dp_op),
        .i_amount (i_amount),
        .i_stock  (r_stock),
        .o_stat   (dp_stat),
        .o_ok     (dp_ok),
        .o_least  (dp_least),
        .o_cnt    (dp_cnt)
    );

    for (genvar k = 0; k < DENOM_SLOTS; k++) begin : g_give
        if (k < NUM_DENOMS) begin : g_used
            assign give_n[k] = dp_ok ? dp_cnt[k] : '0;
        end else begin : g_unused
            assign give_n[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DENOM_SLOTS; k++) begin
                r_stock[k] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(DENOM_SLOTS))) begin
            r_stock[i_cfg_index[DK_W-1:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_paid_ok   <= dp_ok;
            r_shortfall <= dp_ok ? '0 : dp_least;
            r_give      <= give_n;
        end
    end

    assign o_stall     = (seq_op != OP_INIT);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_paid_ok   = r_paid_ok;
    assign o_shortfall = r_shortfall;
    assign o_give_200  = r_give[0];
    assign o_give_100  = r_give[1];
    assign o_give_50   = r_give[2];
    assign o_give_20   = r_give[3];
    assign o_give_10   = r_give[4];
    assign o_give_5    = r_give[5];
    assign o_give_2    = r_give[6];
    assign o_give_1    = r_give[7];

endmodule
`default_nettype wire

// File: rtl/core/bcm_useq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none
module bcm_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bcm_pkg::t_flags i_flags,
    output bcm_pkg::t_op    o_op
);
    import bcm_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword cw;
    logic   jump;

    always_comb begin
        cw = ucode(r_upc);
        case (cw.cond)
            C_NEVER:  jump = 1'b0;
            C_ALWAYS: jump = 1'b1;
            C_NSTART: jump = i_flags.nstart;
            C_JEND:   jump = i_flags.dp.j_end;
            C_SUBNZ:  jump = i_flags.dp.sub_nz;
            C_REMZ:   jump = i_flags.dp.rem_zero;
            C_JZERO:  jump = i_flags.dp.j_zero;
            C_MISS:   jump = i_flags.dp.miss;
            C_OBUSY:  jump = i_flags.out_busy;
            default:  jump = 1'b0;
        endcase
        n_upc = jump ? cw.tgt : r_upc + t_upc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_op = cw.op;

endmodule
`default_nettype wire

// File: rtl/core/bcm_dpath.sv
// Datapath: remainder, piece counts, per-denomination remainders and the reciprocal multiply steps.
`default_nettype none
module bcm_dpath #(
    parameter int NUM_DENOMS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bcm_pkg::t_op               i_op,
    input  logic [bcm_pkg::AMT_W-1:0]  i_amount,
    input  logic [bcm_pkg::CNT_W-1:0]  i_stock [bcm_pkg::DENOM_SLOTS],
    output bcm_pkg::t_dstat            o_stat,
    output logic                       o_ok,
    output logic [bcm_pkg::AMT_W-1:0]  o_least,
    output logic [bcm_pkg::CNT_W-1:0]  o_cnt [NUM_DENOMS]
);
    import bcm_pkg::*;

    localparam int JW = $clog2(NUM_DENOMS + 1);
    localparam int IW = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
    localparam logic [JW-1:0] N_J = JW'(NUM_DENOMS);

    logic [JW-1:0]     r_j;
    logic              r_first;
    logic              r_ok;
    logic [AMT_W-1:0]  r_rem;
    logic [AMT_W-1:0]  r_least;
    logic [CNT_W-1:0]  r_cnt [NUM_DENOMS];
    logic [AMT_W-1:0]  r_ra  [NUM_DENOMS];
    logic [PROD_W-1:0] r_prod;
    logic [AMT_W-1:0]  r_q;
    logic [AMT_W-1:0]  r_qd;
    logic [CNT_W-1:0]  r_take;
    logic [TD_W-1:0]   r_td;

    logic [IW-1:0]      ji;
    logic [DK_W-1:0]    dk;
    logic [DVAL_W-1:0]  dval;
    logic [AMT_W-1:0]   dval_a;
    logic [RECIP_W-1:0] recip;
    logic [CNT_W-1:0]   stock;
    logic [CNT_W-1:0]   cnt_j;
    logic [AMT_W-1:0]   ra_j;
    logic [PROD_W-1:0]  prod_full;
    logic [QD_W-1:0]    qd_full;
    logic [AMT_W-1:0]   rdiff;
    logic [AMT_W-1:0]   q_cor;
    logic [CNT_W-1:0]   take;
    logic [TD_W-1:0]    td_full;
    logic [AMT_W-1:0]   rem_sub;
    logic [AMT_W-1:0]   back_ra;

    always_comb begin
        ji        = r_j[IW-1:0];
        dk        = DK_W'(ji);
        dval      = denom_val(dk);
        dval_a    = AMT_W'(dval);
        recip     = denom_recip(dk);
        stock     = i_stock[dk];
        cnt_j     = r_cnt[ji];
        ra_j      = r_ra[ji];
        prod_full = PROD_W'(r_rem) * PROD_W'(recip);
        qd_full   = QD_W'(r_q) * QD_W'(dval);
        rdiff     = r_rem - r_qd;
        q_cor     = r_q + AMT_W'(rdiff >= dval_a);
        take      = (q_cor > AMT_W'(stock)) ? stock : q_cor[CNT_W-1:0];
        td_full   = TD_W'(r_take) * TD_W'(dval);
        rem_sub   = r_rem - AMT_W'(r_td);
        back_ra   = ra_j + dval_a;
    end

    assign o_stat.j_end    = (r_j == N_J);
    assign o_stat.sub_nz   = (rem_sub != '0);
    assign o_stat.rem_zero = (r_rem == '0);
    assign o_stat.j_zero   = (r_j == '0);
    assign o_stat.miss     = !((cnt_j != '0) && (dval_a > r_rem));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j     <= '0;
            r_first <= 1'b1;
            r_ok    <= 1'b0;
        end else begin
            case (i_op)
                OP_INIT: begin
                    r_j     <= '0;
                    r_first <= 1'b1;
                end
                OP_SUB:   r_j <= r_j + JW'(1);
                OP_LEAST: begin
                    r_first <= 1'b0;
                    r_j     <= N_J;
                end
                OP_DEC:   r_j <= r_j - JW'(1);
                OP_GIVE:  r_j <= r_j + JW'(1);
                OP_SETOK: r_ok <= 1'b1;
                OP_FAIL:  r_ok <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_INIT: begin
                r_rem <= i_amount;
                for (int k = 0; k < NUM_DENOMS; k++) begin
                    r_cnt[k] <= '0;
                    r_ra[k]  <= '0;
                end
            end
            OP_MUL1: r_prod <= prod_full;
            OP_QEST: r_q <= r_prod[RECIP_SHIFT +: AMT_W];
            OP_MUL2: r_qd <= qd_full[AMT_W-1:0];
            OP_CORR: r_take <= take;
            OP_TAKE: begin
                r_td      <= td_full;
                r_cnt[ji] <= r_take;
            end
            OP_SUB: begin
                r_rem    <= rem_sub;
                r_ra[ji] <= rem_sub;
                // Once the remainder is gone, nothing below this denomination is paid.
                if (rem_sub == '0) begin
                    for (int k = 0; k < NUM_DENOMS; k++) begin
                        if (k > int'(r_j)) begin
                            r_cnt[k] <= '0;
                            r_ra[k]  <= '0;
                        end
                    end
                end
            end
            OP_LEAST: begin
                if (r_first || (r_rem < r_least)) begin
                    r_least <= r_rem;
                end
            end
            OP_GIVE: begin
                r_cnt[ji] <= cnt_j - CNT_W'(1);
                r_ra[ji]  <= back_ra;
                r_rem     <= back_ra;
            end
            default: ;
        endcase
    end

    assign o_ok    = r_ok;
    assign o_least = r_least;
    assign o_cnt   = r_cnt;

endmodule
`default_nettype wire

// File: rtl/core/bcm_checker.sv
// Port-level checks for the change maker and their binding to the top level.
`default_nettype none
module bcm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [bcm_pkg::AMT_W-1:0]     i_amount,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_paid_ok,
    input logic [bcm_pkg::AMT_W-1:0]     o_shortfall,
    input logic [bcm_pkg::CNT_W-1:0]     o_give_200,
    input logic [bcm_pkg::CNT_W-1:0]     o_give_100,
    input logic [bcm_pkg::CNT_W-1:0]     o_give_50,
    input logic [bcm_pkg::CNT_W-1:0]     o_give_20,
    input logic [bcm_pkg::CNT_W-1:0]     o_give_10,
    input logic [bcm_pkg::CNT_W-1:0]     o_give_5,
    input logic [bcm_pkg::CNT_W-1:0]     o_give_2,
    input logic [bcm_pkg::CNT_W-1:0]     o_give_1
);
    logic any_give;

    assign any_give = (o_give_200 != '0) || (o_give_100 != '0) || (o_give_50 != '0)
                   || (o_give_20 != '0) || (o_give_10 != '0) || (o_give_5 != '0)
                   || (o_give_2 != '0) || (o_give_1 != '0);

    // A taken request keeps the block busy for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while previous request still in progress");

    a_hold_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_amount)))
        else $error("stalled request beat changed before it was taken");

    a_ok_no_shortfall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_paid_ok) |-> (o_shortfall == '0))
        else $error("successful payout reports a shortfall");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_paid_ok) |-> (!any_give && (o_shortfall != '0)))
        else $error("failed payout carries pieces or a zero shortfall");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat presented right after reset");

endmodule

bind bounded_change_maker_top bcm_checker u_bcm_checker (.*);
`default_nettype wire

// File: sim/bounded_change_maker_top_test.sv
// Self-checking testbench for the bounded change maker: predicts each payout and checks every result beat.
module bounded_change_maker_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = bcm_pkg::DENOM_SLOTS;
    localparam int AW = bcm_pkg::AMT_W;
    localparam int CW = bcm_pkg::CNT_W;
    localparam int IW = bcm_pkg::CFG_IDX_W;
    localparam int N_USED = 8;
    localparam logic [0:SLOTS-1][7:0] COIN =
        {8'd200, 8'd100, 8'd50, 8'd20, 8'd10, 8'd5, 8'd2, 8'd1};
    localparam logic [AW-1:0] AMT_MAX = '1;
    localparam logic [IW-1:0] CFG_IDX_LAST = '1;
    localparam int STEP_CAP = 24;
    localparam int BLOCK_LATENCY = 7 * N_USED + 5;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS = 195;
    localparam int PRINT_LIMIT = 40;

    typedef enum logic [IW-1:0] {
        REG_STOCK_200, REG_STOCK_100, REG_STOCK_50, REG_STOCK_20,
        REG_STOCK_10, REG_STOCK_5, REG_STOCK_2, REG_STOCK_1
    } t_stock_reg;

    typedef enum logic [1:0] {STOCK_ZERO, STOCK_FULL, STOCK_RANDOM, STOCK_SPARSE} t_stock_mix;

    typedef struct packed {
        logic                         paid_ok;
        logic [AW-1:0]                shortfall;
        logic [0:SLOTS-1][CW-1:0]     give;
    } t_payout;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic [AW-1:0] i_amount = '0;
    logic          i_stall = 1'b0;
    logic          i_cfg_valid = 1'b0;
    logic [IW-1:0] i_cfg_index = '0;
    logic [CW-1:0] i_cfg_data = '0;
    logic          o_stall, o_valid, o_paid_ok, o_cfg_ready;
    logic [AW-1:0] o_shortfall;
    logic [CW-1:0] o_give_200, o_give_100, o_give_50, o_give_20;
    logic [CW-1:0] o_give_10, o_give_5, o_give_2, o_give_1;

    // Stock as the block should hold it, and scratch space of the payout search.
    logic [0:SLOTS-1][CW-1:0] stock = '0;
    logic [0:SLOTS-1][CW-1:0] pieces;
    logic [0:SLOTS-1][AW-1:0] left_after;

    logic [AW-1:0] amount_q[$];
    t_payout       payout_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    int result_count = 0;
    t_payout drv_pay;
    t_payout mon_got;
    t_payout mon_want;

    bounded_change_maker_top #(
        .NUM_DENOMS(N_USED)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_amount(i_amount),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_paid_ok(o_paid_ok),
        .o_shortfall(o_shortfall),
        .o_give_200(o_give_200),
        .o_give_100(o_give_100),
        .o_give_50(o_give_50),
        .o_give_20(o_give_20),
        .o_give_10(o_give_10),
        .o_give_5(o_give_5),
        .o_give_2(o_give_2),
        .o_give_1(o_give_1),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Greedy pass over denominations from 'from' down; returns what is left to pay.
    function automatic logic [AW-1:0] greedy_fill(input logic [AW-1:0] start, input int from);
        logic [AW-1:0] rem;
        logic [AW-1:0] take;
        int j, k;
        rem = start;
        for (j = from; j < N_USED; j++) begin
            take = rem / AW'(COIN[j]);
            if (take > AW'(stock[j])) take = AW'(stock[j]);
            pieces[j] = take[CW-1:0];
            rem = rem - take * AW'(COIN[j]);
            left_after[j] = rem;
            if (rem == 0) begin
                for (k = j + 1; k < SLOTS; k++) begin
                    pieces[k] = '0;
                    left_after[k] = '0;
                end
                return '0;
            end
        end
        return rem;
    endfunction

    // Returns the number of give-back steps, or -1 when the search runs past STEP_CAP.
    function automatic int settle_payout(input logic [AW-1:0] amount, output t_payout pay);
        logic [AW-1:0] rem, least;
        logic ok;
        int i, k, steps;
        pay = '0;
        pieces = '0;
        left_after = '0;
        rem = greedy_fill(amount, 0);
        least = rem;
        ok = 1'b1;
        steps = 0;
        while (ok && rem != 0) begin
            // Smallest denomination still in use that is worth more than the remainder.
            i = N_USED - 1;
            while (i >= 0 && (pieces[i] == 0 || AW'(COIN[i]) <= rem)) i--;
            if (i < 0) begin
                ok = 1'b0;
            end else if (steps == STEP_CAP) begin
                return -1;
            end else begin
                steps++;
                pieces[i] = pieces[i] - CW'(1);
                left_after[i] = left_after[i] + AW'(COIN[i]);
                rem = greedy_fill(left_after[i], i + 1);
                if (rem < least) least = rem;
            end
        end
        pay.paid_ok = ok;
        pay.shortfall = ok ? '0 : least;
        for (k = 0; k < SLOTS; k++) pay.give[k] = (ok && k < N_USED) ? pieces[k] : '0;
        return steps;
    endfunction

    // Amounts whose search would run very long are redrawn.
    function automatic logic [AW-1:0] pick_amount();
        t_payout scratch;
        logic [AW-1:0] cand;
        int reach, tries, k, roll;
        reach = 0;
        for (k = 0; k < N_USED; k++) reach += int'(stock[k]) * int'(COIN[k]);
        for (tries = 0; tries < 50; tries++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) cand = AW'($urandom_range(0, 700));
            else if (roll < 70) cand = AW'($urandom_range(0, reach));
            else if (roll < 85) cand = AW'($urandom_range(0, AMT_MAX));
            else if (roll < 92) cand = AW'(reach);
            else if (roll < 96) cand = AMT_MAX;
            else cand = '0;
            if (settle_payout(cand, scratch) >= 0) return cand;
        end
        return '0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("mismatch %s: got %0d, expected %0d at result beat %0d",
                     what, got, want, result_count);
        error_count++;
    endtask

    task automatic write_stock(input logic [IW-1:0] idx, input logic [CW-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx < SLOTS) stock[idx] = val;
    endtask

    task automatic load_stocks(input logic [0:SLOTS-1][CW-1:0] v);
        int k;
        for (k = 0; k < SLOTS; k++) write_stock(k[IW-1:0], v[k]);
    endtask

    task automatic wait_drained();
        while (amount_q.size() != 0 || i_valid || payout_q.size() != 0) @(posedge i_clk);
        repeat (BLOCK_LATENCY) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Request driver: a stalled beat holds its amount until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                void'(settle_payout(i_amount, drv_pay));
                payout_q.push_back(drv_pay);
            end
            if (!i_valid || !o_stall) begin
                if (amount_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_amount <= amount_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall: a requested hold-off overrides the random stall while hold_left counts down.
    always @(posedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (payout_q.size() == 0) begin
                report_mismatch("result beat without request", 1, 0);
            end else begin
                mon_want = payout_q.pop_front();
                mon_got.paid_ok = o_paid_ok;
                mon_got.shortfall = o_shortfall;
                mon_got.give = {o_give_200, o_give_100, o_give_50, o_give_20,
                                o_give_10, o_give_5, o_give_2, o_give_1};
                if (mon_got.paid_ok !== mon_want.paid_ok)
                    report_mismatch("o_paid_ok", 32'(mon_got.paid_ok),
                                    32'(mon_want.paid_ok));
                if (mon_got.shortfall !== mon_want.shortfall)
                    report_mismatch("o_shortfall", 32'(mon_got.shortfall),
                                    32'(mon_want.shortfall));
                for (int k = 0; k < SLOTS; k++)
                    if (mon_got.give[k] !== mon_want.give[k])
                        report_mismatch($sformatf("o_give_%0d", COIN[k]),
                                        32'(mon_got.give[k]), 32'(mon_want.give[k]));
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int ph, i, n, k;
        t_stock_mix mix;
        logic [0:SLOTS-1][CW-1:0] fresh;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(17, 79);

        // Empty stock after reset: only a zero amount can be paid.
        amount_q.push_back('0);
        amount_q.push_back(AMT_MAX);
        amount_q.push_back(AW'(1));
        wait_drained();

        load_stocks('1);
        write_stock(CFG_IDX_LAST, 8'h5A);
        amount_q.push_back('0);
        amount_q.push_back(AMT_MAX);
        amount_q.push_back(AW'(98940));  // every piece of a full stock
        amount_q.push_back(AW'(65536));
        amount_q.push_back(AW'(250));
        amount_q.push_back(AW'(199));
        amount_q.push_back(AW'(201));
        amount_q.push_back(AW'(7));
        amount_q.push_back(AW'(3));
        wait_drained();

        // One fifty and three twenties: 60 needs the fifty given back.
        load_stocks({8'd0, 8'd0, 8'd1, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0});
        amount_q.push_back(AW'(60));
        amount_q.push_back(AW'(50));
        amount_q.push_back(AW'(10));
        wait_drained();
        write_stock(REG_STOCK_20, 8'd2);
        amount_q.push_back(AW'(60));
        wait_drained();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 3) set_idling(17, 79);
            else if (ph < 6) set_idling(79, 17);
            else set_idling(0, 0);
            case (ph)
                1, 5, 7: mix = STOCK_RANDOM;
                2:       mix = STOCK_FULL;
                4:       mix = STOCK_ZERO;
                default: mix = STOCK_SPARSE;
            endcase
            case (mix)
                STOCK_ZERO: fresh = '0;
                STOCK_FULL: fresh = '1;
                STOCK_RANDOM: begin
                    for (k = 0; k < SLOTS; k++) fresh[k] = CW'($urandom_range(0, 255));
                end
                default: begin
                    for (k = 0; k < SLOTS; k++)
                        fresh[k] = ($urandom_range(0, 9) < 4) ? 8'd0
                                                              : CW'($urandom_range(1, 4));
                end
            endcase
            load_stocks(fresh);
            if ($urandom_range(0, 2) == 0)
                write_stock(IW'($urandom_range(SLOTS, CFG_IDX_LAST)),
                            CW'($urandom_range(0, 255)));

            n = (mix == STOCK_ZERO) ? 60 : PHASE_ITEMS;
            for (i = 0; i < n; i++) begin
                if (ph == 3 && i == n / 2) wait_drained();
                amount_q.push_back(pick_amount());
            end
            // Long result hold-off while requests keep coming, so the block backs up.
            if (ph == 6) hold_asks <= hold_asks + 1;
            wait_drained();
        end

        if (payout_q.size() != 0) report_mismatch("results still owed", 0, payout_q.size());
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: bounded_change_maker_top.f
rtl/core/bcm_pkg.sv
rtl/core/bcm_useq.sv
rtl/core/bcm_dpath.sv
rtl/core/bounded_change_maker_top.sv
rtl/core/bcm_checker.sv
sim/bounded_change_maker_top_test.sv
